>>> hw/rtl/phng_pkg.sv
// Shared constants for the packet header nonce generator.
package phng_pkg;

    localparam int POOL_SIZE = 10;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);

    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam int GEN_W     = 32;
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = GEN_W / MOD_BITS;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    localparam logic [GEN_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [GEN_W-1:0] LCG_ADD = 32'd1013904223;
    localparam logic [GEN_W-1:0] SEED_RESET = 32'd1;

    localparam logic [7:0] CMD_CHECK = 8'd67;
    localparam logic [7:0] CMD_STOP  = 8'd83;
    localparam logic [1:0] MSG_CHECK = 2'd1;

    localparam logic REG_SEED = 1'b0;

endpackage

>>> hw/rtl/phng_req_if.sv
// Request channel: one transaction asks for one packet header.
interface phng_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] message_type;

    modport source (output valid, output message_type, input ready);
    modport sink   (input valid, input message_type, output ready);
endinterface

>>> hw/rtl/phng_rsp_if.sv
// Response channel: command byte, sequence number and nonce of one header.
interface phng_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  command_byte;
    logic [15:0] sequence_number;
    logic [15:0] nonce_value;

    modport source (output valid, output command_byte, output sequence_number,
                    output nonce_value, input ready);
    modport sink   (input valid, input command_byte, input sequence_number,
                    input nonce_value, output ready);
endinterface

>>> hw/rtl/packet_header_nonce_generator_core.sv
// Packet header nonce generator: shuffled nonce pool, sequence count, LCG.
//
// Usage:
//   req carries one transaction per header (message_type 1 = check, else stop).
//   rsp returns command byte ('C' or 'S'), sequence number and nonce.
//   APB port holds random_seed at address 0; a write also reloads the LCG.
// Operation:
//   A transaction from the pool memory is accepted, read and registered.
//   A transaction that finds all POOL_SIZE entries used first refills the
//   pool: POOL_SIZE writes, then POOL_SIZE-1 swaps, each of one LCG
//   multiply, 4-bit remainder steps over the LCG value, one dual read and
//   two writes on the single write port.
//   One transaction is in the pool at a time.
// Reset:
//   Counters clear, seed and LCG state load 1, the pool reads as zeros
//   until its first refill.
// Stall:
//   The response register holds while rsp.ready is low; one further request
//   is accepted and waits for the register to free before it is delivered.
module packet_header_nonce_generator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    phng_req_if.sink                          req,
    phng_rsp_if.source                        rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [phng_pkg::ADDR_W-1:0]       paddr,
    input  logic [phng_pkg::DATA_W-1:0]       pwdata,
    output logic [phng_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_READ    = 4'd1;
    localparam logic [3:0] S_DELIVER = 4'd2;
    localparam logic [3:0] S_FILL    = 4'd3;
    localparam logic [3:0] S_LCG     = 4'd4;
    localparam logic [3:0] S_MOD     = 4'd5;
    localparam logic [3:0] S_SWP_RD  = 4'd6;
    localparam logic [3:0] S_SWP_W1  = 4'd7;
    localparam logic [3:0] S_SWP_W2  = 4'd8;

    localparam int IW = phng_pkg::IDX_W;
    localparam int CW = phng_pkg::CNT_W;
    localparam int GW = phng_pkg::GEN_W;

    logic [3:0]                     state_reg, state_next;
    logic [GW-1:0]                  seed_reg, seed_next;
    logic [GW-1:0]                  gen_reg, gen_next;
    logic [GW-1:0]                  modx_reg, modx_next;
    logic [IW:0]                    rem_reg, rem_next;
    logic [phng_pkg::MOD_CNT_W-1:0] modcnt_reg, modcnt_next;
    logic [IW-1:0]                  fill_reg, fill_next;
    logic [IW-1:0]                  swpi_reg, swpi_next;
    logic [IW-1:0]                  swpj_reg, swpj_next;
    logic [CW-1:0]                  rdidx_reg, rdidx_next;
    logic [15:0]                    base_reg, base_next;
    logic [15:0]                    count_reg, count_next;
    logic                           filled_reg, filled_next;
    logic [1:0]                     msg_reg, msg_next;
    logic                           oval_reg, oval_next;
    logic [7:0]                     ocmd_reg, ocmd_next;
    logic [15:0]                    oseq_reg, oseq_next;
    logic [15:0]                    ononce_reg, ononce_next;

    logic [15:0] pool_mem [phng_pkg::POOL_SIZE];
    logic [15:0] rda_reg, rdb_reg;
    logic        mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
    logic [15:0] mem_wdata;

    logic        cfg_wr;
    logic        req_acc;
    logic        slot_free;
    logic [IW:0] rem_v;
    logic [GW-1:0] lcg_v;
    logic [15:0] nonce_rd;

    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite & (paddr[2] == phng_pkg::REG_SEED);
    assign prdata    = (paddr[2] == phng_pkg::REG_SEED) ? seed_reg : '0;
    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid & req.ready;
    assign slot_free = ~oval_reg | rsp.ready;
    assign lcg_v     = gen_reg * phng_pkg::LCG_MUL + phng_pkg::LCG_ADD;
    assign nonce_rd  = filled_reg ? rda_reg : 16'd0;

    assign rsp.valid           = oval_reg;
    assign rsp.command_byte    = ocmd_reg;
    assign rsp.sequence_number = oseq_reg;
    assign rsp.nonce_value     = ononce_reg;

    // restoring remainder, 4 bits of the LCG value per cycle
    always_comb
    begin
        rem_v = rem_reg;
        for (int k = 0; k < phng_pkg::MOD_BITS; k++)
        begin
            rem_v = {rem_v[IW-1:0], modx_reg[GW-1-k]};
            if (rem_v >= {1'b0, swpi_reg})
            begin
                rem_v = rem_v - {1'b0, swpi_reg};
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        seed_next   = seed_reg;
        gen_next    = gen_reg;
        modx_next   = modx_reg;
        rem_next    = rem_reg;
        modcnt_next = modcnt_reg;
        fill_next   = fill_reg;
        swpi_next   = swpi_reg;
        swpj_next   = swpj_reg;
        rdidx_next  = rdidx_reg;
        base_next   = base_reg;
        count_next  = count_reg;
        filled_next = filled_reg;
        msg_next    = msg_reg;
        oval_next   = oval_reg & ~rsp.ready;
        ocmd_next   = ocmd_reg;
        oseq_next   = oseq_reg;
        ononce_next = ononce_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = fill_reg;
        mem_wdata   = base_reg + 16'(fill_reg);
        mem_raddr_a = rdidx_reg[IW-1:0];
        mem_raddr_b = swpj_reg;

        if (cfg_wr)
        begin
            seed_next = pwdata;
            gen_next  = pwdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    msg_next = req.message_type;
                    if (rdidx_reg == CW'(phng_pkg::POOL_SIZE))
                    begin
                        base_next  = base_reg + 16'(phng_pkg::POOL_SIZE);
                        fill_next  = '0;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (slot_free)
                begin
                    oval_next   = 1'b1;
                    ocmd_next   = (msg_reg == phng_pkg::MSG_CHECK) ?
                                  phng_pkg::CMD_CHECK : phng_pkg::CMD_STOP;
                    oseq_next   = count_reg;
                    ononce_next = nonce_rd;
                    count_next  = count_reg + 16'd1;
                    rdidx_next  = rdidx_reg + CW'(1);
                    state_next  = S_IDLE;
                end
            end
            S_FILL:
            begin
                mem_we      = 1'b1;
                filled_next = 1'b1;
                fill_next   = fill_reg + IW'(1);
                if (fill_reg == IW'(phng_pkg::POOL_SIZE - 1))
                begin
                    swpi_next  = IW'(phng_pkg::POOL_SIZE - 1);
                    state_next = S_LCG;
                end
            end
            S_LCG:
            begin
                gen_next    = lcg_v;
                modx_next   = lcg_v;
                rem_next    = '0;
                modcnt_next = '0;
                state_next  = S_MOD;
            end
            S_MOD:
            begin
                rem_next    = rem_v;
                modx_next   = modx_reg << phng_pkg::MOD_BITS;
                modcnt_next = modcnt_reg + phng_pkg::MOD_CNT_W'(1);
                if (modcnt_reg == phng_pkg::MOD_CNT_W'(phng_pkg::MOD_STEPS - 1))
                begin
                    swpj_next  = rem_v[IW-1:0];
                    state_next = S_SWP_RD;
                end
            end
            S_SWP_RD:
            begin
                mem_re      = 1'b1;
                mem_raddr_a = swpi_reg;
                state_next  = S_SWP_W1;
            end
            S_SWP_W1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = swpi_reg;
                mem_wdata  = rdb_reg;
                state_next = S_SWP_W2;
            end
            S_SWP_W2:
            begin
                mem_we    = 1'b1;
                mem_waddr = swpj_reg;
                mem_wdata = rda_reg;
                // last swap writes entry 0 with rda_reg, which stays as the first nonce
                if (swpi_reg == IW'(1))
                begin
                    rdidx_next = '0;
                    state_next = S_READ;
                end
                else
                begin
                    swpi_next  = swpi_reg - IW'(1);
                    state_next = S_LCG;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // pool memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pool_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rda_reg <= pool_mem[mem_raddr_a];
            rdb_reg <= pool_mem[mem_raddr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        modx_reg   <= modx_next;
        rem_reg    <= rem_next;
        swpj_reg   <= swpj_next;
        msg_reg    <= msg_next;
        ocmd_reg   <= ocmd_next;
        oseq_reg   <= oseq_next;
        ononce_reg <= ononce_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            seed_reg   <= phng_pkg::SEED_RESET;
            gen_reg    <= phng_pkg::SEED_RESET;
            modcnt_reg <= '0;
            fill_reg   <= '0;
            swpi_reg   <= '0;
            rdidx_reg  <= '0;
            base_reg   <= '0;
            count_reg  <= '0;
            filled_reg <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            seed_reg   <= seed_next;
            gen_reg    <= gen_next;
            modcnt_reg <= modcnt_next;
            fill_reg   <= fill_next;
            swpi_reg   <= swpi_next;
            rdidx_reg  <= rdidx_next;
            base_reg   <= base_next;
            count_reg  <= count_next;
            filled_reg <= filled_next;
            oval_reg   <= oval_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_swap_below_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWP_W1) |-> (swpj_reg < swpi_reg))
        else $error("swap partner not below current slot");

    a_deliver_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DELIVER) |-> (rdidx_reg < CW'(phng_pkg::POOL_SIZE)))
        else $error("pool read index past end at delivery");

    a_refill_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWP_W2 && swpi_reg == IW'(1))
        |=> (rdidx_reg == '0 && filled_reg && state_reg == S_READ))
        else $error("refill did not restart pool at entry zero");

    a_rsp_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DELIVER && slot_free)
        |=> (rsp.valid && rsp.sequence_number == $past(count_reg)))
        else $error("response not loaded with current sequence count");
`endif

endmodule

>>> tb/phng_header_checker.sv
// Checker for the nonce generator: predicts each header from the request stream and compares.
module phng_header_checker
    import phng_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    phng_req_if               req,
    phng_rsp_if               rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    output int                outstanding,
    output int                fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  command_byte;
        logic [15:0] sequence_number;
        logic [15:0] nonce_value;
    } header_t;

    header_t           expected_headers[$];

    logic [GEN_W-1:0]  seed_reg;
    logic [GEN_W-1:0]  lcg_state;
    logic [15:0]       pool [POOL_SIZE];
    int                read_idx;
    logic [15:0]       pool_base;
    logic [15:0]       packet_count;

    function automatic void reshuffle_pool();
        logic [15:0]      tmp;
        logic [GEN_W-1:0] span;
        int               j;
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = pool_base + 16'(i);
        // Sattolo pass, top slot downwards
        for (int i = POOL_SIZE - 1; i > 0; i--)
        begin
            lcg_state = lcg_state * LCG_MUL + LCG_ADD;
            span      = i;
            j         = int'(lcg_state % span);
            tmp       = pool[i];
            pool[i]   = pool[j];
            pool[j]   = tmp;
        end
        read_idx = 0;
    endfunction

    function automatic header_t build_header(input logic [1:0] kind);
        header_t h;
        if (read_idx >= POOL_SIZE)
        begin
            pool_base = pool_base + 16'(POOL_SIZE);
            reshuffle_pool();
        end
        h.command_byte    = (kind == MSG_CHECK) ? CMD_CHECK : CMD_STOP;
        h.sequence_number = packet_count;
        h.nonce_value     = pool[read_idx];
        read_idx++;
        packet_count++;
        return h;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        header_t exp_h;
        header_t got_h;
        int      errs;
        errs = 0;
        if (!rst_n)
        begin
            seed_reg     = SEED_RESET;
            lcg_state    = SEED_RESET;
            read_idx     = 0;
            pool_base    = '0;
            packet_count = '0;
            for (int i = 0; i < POOL_SIZE; i++)
                pool[i] = '0;
            expected_headers.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_SEED)
            begin
                if (pwrite)
                begin
                    seed_reg  = pwdata;
                    lcg_state = pwdata;
                end
                else if (prdata !== seed_reg)
                begin
                    $display("%0t: seed readback expected %h actual %h", $time, seed_reg, prdata);
                    errs++;
                end
            end

            if (req.valid && req.ready)
                expected_headers.push_back(build_header(req.message_type));

            if (rsp.valid && rsp.ready)
            begin
                got_h = {rsp.command_byte, rsp.sequence_number, rsp.nonce_value};
                if (expected_headers.size() == 0)
                begin
                    $display("%0t: unexpected transaction expected none actual %h", $time, got_h);
                    errs++;
                end
                else
                begin
                    exp_h = expected_headers.pop_front();
                    if (got_h.command_byte !== exp_h.command_byte
                        || got_h.sequence_number !== exp_h.sequence_number
                        || got_h.nonce_value !== exp_h.nonce_value)
                    begin
                        $display("%0t: header expected %h/%h/%h actual %h/%h/%h",
                                 $time, exp_h.command_byte, exp_h.sequence_number,
                                 exp_h.nonce_value, got_h.command_byte,
                                 got_h.sequence_number, got_h.nonce_value);
                        errs++;
                    end
                end
            end
            outstanding <= expected_headers.size();
            fail_count  <= fail_count + errs;
        end
    end

endmodule

>>> tb/tb_packet_header_nonce_generator_core.sv
// Testbench top for the packet header nonce generator: stimulus, APB set-up and verdict.
module tb_packet_header_nonce_generator_core;
    import phng_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_SEED = 305;
    localparam int WATCHDOG_LIMIT  = 3000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                outstanding;
    int                fail_count;
    int                headers_sent;
    int                seed_writes;
    int                idle_cycles;
    bit                gaps_on;

    phng_req_if req_ch ();
    phng_rsp_if rsp_ch ();

    packet_header_nonce_generator_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    phng_header_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        rsp_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= 24);

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_header(input logic [1:0] kind);
        while (gaps_on && $urandom_range(0, 99) < 24)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.message_type <= kind;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        headers_sent++;
    endtask

    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // block is idle once every header is back and the pipe has settled
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic load_seed(input logic [DATA_W-1:0] seed);
        drain();
        apb_access(1'b1, ADDR_W'(0), seed);
        apb_access(1'b0, ADDR_W'(0), '0);
        seed_writes++;
    endtask

    task automatic random_headers(input int count);
        logic [1:0] kind;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 75)
                kind = MSG_CHECK;
            else
                kind = 2'($urandom_range(0, 3));
            send_header(kind);
        end
    endtask

    initial
    begin
        logic [DATA_W-1:0] seeds [6];
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.message_type <= '0;
        headers_sent         = 0;
        seed_writes          = 0;
        gaps_on              = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset seed readback, then zero pool, first refill, all message kinds
        apb_access(1'b0, ADDR_W'(0), '0);
        for (int i = 0; i < 12; i++)
            send_header(2'(i));
        drain();
        // unmapped register index: must leave the seed alone
        apb_access(1'b1, ADDR_W'(4), $urandom());
        apb_access(1'b0, ADDR_W'(0), '0);
        for (int i = 0; i < 10; i++)
            send_header((i % 3 == 0) ? 2'd3 : MSG_CHECK);

        seeds[0] = 32'h0000_0000;
        seeds[1] = 32'hFFFF_FFFF;
        seeds[2] = $urandom();
        seeds[3] = $urandom();
        seeds[4] = 32'h8000_0000 | $urandom();
        seeds[5] = SEED_RESET;
        for (int s = 0; s < 6; s++)
        begin
            load_seed(seeds[s]);
            gaps_on = (s != 1);
            random_headers(RANDOM_PER_SEED);
            gaps_on = 1'b1;
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d header requests over %0d seed loads, seeds 0 and all-ones too,",
                 headers_sent, seed_writes);
        $display("with random stalls on both channels and one stretch at full rate.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
